[sv/nags_pkg.sv]
// Shared types, sizes and helpers for the neighbour absolute gradient stream unit.
// No dependencies; used by neighbour_abs_gradient_stream_unit.

package nags_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIXEL_BITS = 16;
  localparam int GRAD_BITS  = 18;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int FW_BITS    = 12;
  localparam int FH_BITS    = 13;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [FW_BITS-1:0] WIDTH_RESET  = FW_BITS'(640);
  localparam logic [FH_BITS-1:0] HEIGHT_RESET = FH_BITS'(480);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

  // Result kinds an item may cause, in emission order.
  localparam int EMIT_MAIN  = 0;
  localparam int EMIT_LAST  = 1;
  localparam int EMIT_FINAL = 2;
  localparam int EMIT_KINDS = 3;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  // Line memory word: pixel of the row above and its difference to the row before it.
  typedef struct packed {
    pixel_t pix;
    pixel_t up_diff;
  } line_word_t;

  // Which neighbours of the answered pixel lie inside the frame.
  typedef struct packed {
    logic has_left;
    logic has_right;
    logic has_up;
    logic has_far_left;
  } nbr_flags_t;

  function automatic pixel_t absdiff(input pixel_t a, input pixel_t b);
    pixel_t d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

endpackage

[sv/neighbour_abs_gradient_stream_unit.sv]
// Neighbour absolute gradient stream unit: top level with line memory and result stage.
// Depends on nags_pkg for sizes, the memory word type and the absdiff helper.
//
// Usage:
//   Pixels enter in raster order on in_valid/in_stall/pixel, one beat per pixel.
//   Results leave on out_valid/out_stall with gradient, out_col, out_row,
//   last_of_run and frame_done. A pixel of every row but the last is answered
//   when the pixel below it arrives; a last-row pixel when its right neighbour
//   arrives; the frame's final pixel answers itself with frame_done set.
//   Frame size is set through cfg_valid/cfg_ready/cfg_index/cfg_data; any write
//   to a known index restarts the frame. cfg_ready is always high.
// Path: a taken beat enters the item register, and its first result is then loaded
//   into the output register.
// Throughput: one pixel per cycle in all rows but the last, while out_stall is low.
//   A last-row pixel after the first causes two results, the final pixel three; the
//   single output register, loaded once per cycle, takes them in turn.
// Reset: counters return to the frame origin, size returns to 640 x 480 and
//   both pipeline registers empty. The line memory holds no reset value; each
//   entry is written in a row before the next row reads it.
// Stall: while out_stall holds the output register, an item with results stays in
//   the item register and in_stall rises until its last result is loaded.

module neighbour_abs_gradient_stream_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [nags_pkg::PIXEL_BITS-1:0]       pixel,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [nags_pkg::GRAD_BITS-1:0]        gradient,
  output logic [nags_pkg::COL_BITS-1:0]         out_col,
  output logic [nags_pkg::ROW_BITS-1:0]         out_row,
  output logic                                  last_of_run,
  output logic                                  frame_done,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [nags_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [nags_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  // Configuration and frame position.
  logic [nags_pkg::FW_BITS-1:0]  frame_width;
  logic [nags_pkg::FH_BITS-1:0]  frame_height;
  logic [nags_pkg::COL_BITS-1:0] col_count;
  logic [nags_pkg::ROW_BITS-1:0] row_count;

  logic [nags_pkg::FW_BITS-1:0]  width_eff;
  logic [nags_pkg::FH_BITS-1:0]  height_eff;
  logic [nags_pkg::FW_BITS-1:0]  width_m1;
  logic [nags_pkg::FH_BITS-1:0]  height_m1;
  logic [nags_pkg::COL_BITS-1:0] last_col;
  logic [nags_pkg::ROW_BITS-1:0] last_row;

  // Item register.
  logic                               r_valid;
  logic [nags_pkg::EMIT_KINDS-1:0]    r_mask;
  nags_pkg::nbr_flags_t               r_flags;
  nags_pkg::pixel_t                   r_pix;
  nags_pkg::pixel_t                   r_prev1;
  nags_pkg::pixel_t                   r_prev2;
  nags_pkg::pixel_t                   r_left_pix;
  logic [nags_pkg::COL_BITS-1:0]      r_col;
  logic [nags_pkg::ROW_BITS-1:0]      r_row;
  logic                               wr_pend;

  // Line memory and its read registers.
  nags_pkg::line_word_t               line_mem [nags_pkg::MAX_WIDTH];
  nags_pkg::line_word_t               rd_a;
  nags_pkg::line_word_t               rd_b;
  nags_pkg::line_word_t               byp_word;
  logic                               byp_sel;
  nags_pkg::line_word_t               right_word;
  nags_pkg::line_word_t               wr_word;

  logic                               accept;
  logic                               cfg_write;
  logic                               cfg_known;
  logic                               out_free;
  logic                               emit;
  logic                               r_done;
  logic [nags_pkg::COL_BITS-1:0]      col_plus;
  logic                               at_last_col;
  logic                               at_last_row;
  logic [nags_pkg::EMIT_KINDS-1:0]    mask_new;
  nags_pkg::nbr_flags_t               flags_new;
  logic [nags_pkg::EMIT_KINDS-1:0]    mask_next;

  nags_pkg::pixel_t                   d_main;
  logic [nags_pkg::GRAD_BITS-1:0]     g_main;
  logic [nags_pkg::GRAD_BITS-1:0]     g_last;
  logic [nags_pkg::GRAD_BITS-1:0]     g_final;
  logic [nags_pkg::GRAD_BITS-1:0]     sel_grad;
  logic [nags_pkg::COL_BITS-1:0]      sel_col;
  logic [nags_pkg::ROW_BITS-1:0]      sel_row;
  logic                               sel_done;

  // Size clamping.
  always_comb begin
    width_eff = frame_width;
    if (frame_width < nags_pkg::FW_BITS'(2)) begin
      width_eff = nags_pkg::FW_BITS'(2);
    end else if (frame_width > nags_pkg::FW_BITS'(nags_pkg::MAX_WIDTH)) begin
      width_eff = nags_pkg::FW_BITS'(nags_pkg::MAX_WIDTH);
    end
    height_eff = frame_height;
    if (frame_height < nags_pkg::FH_BITS'(2)) begin
      height_eff = nags_pkg::FH_BITS'(2);
    end else if (frame_height > nags_pkg::FH_BITS'(nags_pkg::MAX_HEIGHT)) begin
      height_eff = nags_pkg::FH_BITS'(nags_pkg::MAX_HEIGHT);
    end
    width_m1  = width_eff - nags_pkg::FW_BITS'(1);
    height_m1 = height_eff - nags_pkg::FH_BITS'(1);
    last_col  = width_m1[nags_pkg::COL_BITS-1:0];
    last_row  = height_m1[nags_pkg::ROW_BITS-1:0];
  end

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index == nags_pkg::CFG_FRAME_WIDTH) ||
                     (cfg_index == nags_pkg::CFG_FRAME_HEIGHT);

  assign out_free = !out_valid || !out_stall;
  assign emit     = r_valid && (r_mask != '0) && out_free;
  assign r_done   = r_valid && ((r_mask == '0) || (emit && $onehot(r_mask)));
  assign in_stall = r_valid && !r_done;
  assign accept   = in_valid && !in_stall;

  // What the incoming pixel causes.
  assign col_plus    = col_count + nags_pkg::COL_BITS'(1);
  assign at_last_col = (col_count == last_col);
  assign at_last_row = (row_count == last_row);

  always_comb begin
    mask_new = '0;
    mask_new[nags_pkg::EMIT_MAIN]  = (row_count != '0);
    mask_new[nags_pkg::EMIT_LAST]  = at_last_row && (col_count != '0);
    mask_new[nags_pkg::EMIT_FINAL] = at_last_row && at_last_col;
    flags_new.has_left     = (col_count != '0);
    flags_new.has_right    = !at_last_col;
    flags_new.has_up       = |row_count[nags_pkg::ROW_BITS-1:1];
    flags_new.has_far_left = |col_count[nags_pkg::COL_BITS-1:1];
  end

  // Emission goes lowest kind first; clear that bit once it is loaded.
  always_comb begin
    mask_next = r_mask;
    if (emit) begin
      mask_next = r_mask & (r_mask - nags_pkg::EMIT_KINDS'(1));
    end
  end

  // Configuration and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= nags_pkg::WIDTH_RESET;
      frame_height <= nags_pkg::HEIGHT_RESET;
      col_count    <= '0;
      row_count    <= '0;
    end else if (cfg_write) begin
      if (cfg_index == nags_pkg::CFG_FRAME_WIDTH) begin
        frame_width <= cfg_data[nags_pkg::FW_BITS-1:0];
      end else if (cfg_index == nags_pkg::CFG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
      if (cfg_known) begin
        col_count <= '0;
        row_count <= '0;
      end
    end else if (accept) begin
      if (at_last_col) begin
        col_count <= '0;
        row_count <= at_last_row ? '0 : row_count + nags_pkg::ROW_BITS'(1);
      end else begin
        col_count <= col_plus;
      end
    end
  end

  // Item register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      r_mask  <= '0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= accept;
      if (accept) begin
        r_valid <= 1'b1;
        r_mask  <= mask_new;
      end else begin
        r_mask <= mask_next;
        if (r_done) begin
          r_valid <= 1'b0;
        end
      end
    end
  end

  // Item payload; the previous item's values shift into the history fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      r_flags    <= flags_new;
      r_pix      <= pixel;
      r_prev1    <= r_pix;
      r_prev2    <= r_prev1;
      r_left_pix <= rd_a.pix;
      r_col      <= col_count;
      r_row      <= row_count;
    end
  end

  // The item just taken writes its column in the cycle after it is taken. Only with
  // two-pixel rows can the next item's right-hand read hit that same column.
  assign d_main      = nags_pkg::absdiff(rd_a.pix, r_pix);
  assign wr_word.pix     = r_pix;
  assign wr_word.up_diff = d_main;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a     <= line_mem[col_count];
      rd_b     <= line_mem[col_plus];
      byp_sel  <= wr_pend && (r_col == col_plus);
      byp_word <= wr_word;
    end
    if (wr_pend) begin
      line_mem[r_col] <= wr_word;
    end
  end

  assign right_word = byp_sel ? byp_word : rd_b;

  // Gradients of the three result kinds.
  always_comb begin
    g_main = nags_pkg::GRAD_BITS'(d_main);
    if (r_flags.has_left) begin
      g_main = g_main + nags_pkg::GRAD_BITS'(nags_pkg::absdiff(rd_a.pix, r_left_pix));
    end
    if (r_flags.has_right) begin
      g_main = g_main + nags_pkg::GRAD_BITS'(nags_pkg::absdiff(rd_a.pix, right_word.pix));
    end
    if (r_flags.has_up) begin
      g_main = g_main + nags_pkg::GRAD_BITS'(rd_a.up_diff);
    end

    g_last = nags_pkg::GRAD_BITS'(nags_pkg::absdiff(r_prev1, r_pix)) +
             nags_pkg::GRAD_BITS'(nags_pkg::absdiff(r_prev1, r_left_pix));
    if (r_flags.has_far_left) begin
      g_last = g_last + nags_pkg::GRAD_BITS'(nags_pkg::absdiff(r_prev1, r_prev2));
    end

    g_final = nags_pkg::GRAD_BITS'(nags_pkg::absdiff(r_pix, r_prev1)) +
              nags_pkg::GRAD_BITS'(d_main);
  end

  always_comb begin
    sel_grad = g_final;
    sel_col  = r_col;
    sel_row  = r_row;
    sel_done = 1'b1;
    if (r_mask[nags_pkg::EMIT_MAIN]) begin
      sel_grad = g_main;
      sel_row  = r_row - nags_pkg::ROW_BITS'(1);
      sel_done = 1'b0;
    end else if (r_mask[nags_pkg::EMIT_LAST]) begin
      sel_grad = g_last;
      sel_col  = r_col - nags_pkg::COL_BITS'(1);
      sel_done = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      gradient    <= sel_grad;
      out_col     <= sel_col;
      out_row     <= sel_row;
      last_of_run <= $onehot(r_mask);
      frame_done  <= sel_done;
    end
  end

  // An item with nothing to emit must leave the item register at once.
  assert property (@(posedge clk) disable iff (rst)
    r_valid && (r_mask == '0) |-> !in_stall)
    else $error("item without results held the input");

  // The line memory write follows every taken beat while its item is still held.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> r_valid && wr_pend)
    else $error("taken beat did not reach the item register");

  // The frame closes only on the last result of its final pixel.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last_of_run)
    else $error("frame end without end of run");

  // A result is loaded only while the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(gradient) && $stable(out_col))
    else $error("held result overwritten");

endmodule
